[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the GF(2^m) pentanomial multiplier.
// Define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[design/gf2mpm_pkg.sv]
// ----------------------------------------------------------------------------
// gf2mpm_pkg
// Shared types and constants for the GF(2^m) pentanomial multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gf2mpm_pkg;

  // Fixed field widths
  localparam int DATA_W   = 64;
  localparam int DEGREE_W = 7;
  localparam int TAP_W    = 6;

  // Register port geometry
  localparam int PDATA_W  = 32;
  localparam int PADDR_W  = 4;

  // Horner steps folded into one pipeline stage
  localparam int STEPS_PER_STAGE = 8;

  // Register reset values
  localparam logic [DEGREE_W-1:0] DEGREE_RESET   = 7'd6;
  localparam logic [TAP_W-1:0]    TAP_HIGH_RESET = 6'd4;
  localparam logic [TAP_W-1:0]    TAP_MID_RESET  = 6'd3;
  localparam logic [TAP_W-1:0]    TAP_LOW_RESET  = 6'd1;

  // Register map, word index
  typedef enum logic [1:0] {
    REG_FIELD_DEGREE = 2'd0,
    REG_TAP_HIGH     = 2'd1,
    REG_TAP_MID      = 2'd2,
    REG_TAP_LOW      = 2'd3
  } cfg_reg_t;

endpackage

[design/gf2m_pentanomial_multiplier_top.sv]
// ----------------------------------------------------------------------------
// gf2m_pentanomial_multiplier_top
// GF(2^m) polynomial-basis multiplier, reduction by a configurable pentanomial
// x^m + x^k3 + x^k2 + x^k1 + 1, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Operand channel: multiplier_a and multiplicand_b with operand_valid; a
//   transfer happens when operand_valid is high and operand_stall is low.
//   Product channel: product with product_valid; the receiver holds
//   product_stall high to keep the result in place.
//   Registers field_degree, tap_high, tap_mid and tap_low sit on the APB port
//   at byte addresses 0, 4, 8 and 12; write them only while the pipe is empty.
//   Operand bits at or above the degree are ignored, taps at or above the
//   degree are absent, and product bits at or above the degree are zero.
// Pipeline:
//   One entry register that aligns the operands, one stage per eight Horner
//   steps, and one output register lie between the operand transfer and
//   product_valid.
//   Throughput is one product per cycle while product_stall is low.
// Reset clears all valid bits and loads degree 6 with taps 4, 3 and 1.
// A stalled receiver fills the pipe stage by stage; bubbles are squeezed out
// and operand_stall rises only once the entry register is full and blocked.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module gf2m_pentanomial_multiplier_top
  import gf2mpm_pkg::*;
#(
  parameter int MAX_DEGREE = 64
) (
  input  logic               clk,
  input  logic               rst,
  // Register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // Operand channel
  input  logic               operand_valid,
  output logic               operand_stall,
  input  logic [DATA_W-1:0]  multiplier_a,
  input  logic [DATA_W-1:0]  multiplicand_b,
  // Product channel
  output logic               product_valid,
  input  logic               product_stall,
  output logic [DATA_W-1:0]  product
);

  localparam int W    = MAX_DEGREE;
  localparam int NSTG = (W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int AW   = NSTG * STEPS_PER_STAGE;
  localparam int DW   = $clog2(W + 1);

  // Configuration registers
  logic [DEGREE_W-1:0] field_degree;
  logic [TAP_W-1:0]    tap_high;
  logic [TAP_W-1:0]    tap_mid;
  logic [TAP_W-1:0]    tap_low;

  // Field shape derived from configuration
  logic [DW-1:0] degree;
  logic [DW-1:0] align_sh;
  logic [W-1:0]  mask;
  logic [W-1:0]  poly;
  logic [W-1:0]  poly_al;

  // Entry register
  logic          entry_valid;
  logic          entry_ready;
  logic [AW-1:0] entry_a;
  logic [W-1:0]  entry_b;

  // Stage chain
  logic          ch_valid [NSTG+1];
  logic          ch_ready [NSTG+1];
  logic [W-1:0]  ch_s     [NSTG+1];
  logic [AW-1:0] ch_a     [NSTG+1];
  logic [W-1:0]  ch_b     [NSTG+1];

  // Output register
  logic          out_ready;
  logic [W-1:0]  product_q;

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  // Write on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      field_degree <= DEGREE_RESET;
      tap_high     <= TAP_HIGH_RESET;
      tap_mid      <= TAP_MID_RESET;
      tap_low      <= TAP_LOW_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (cfg_reg_t'(paddr[PADDR_W-1:2]))
        REG_FIELD_DEGREE: field_degree <= pwdata[DEGREE_W-1:0];
        REG_TAP_HIGH:     tap_high     <= pwdata[TAP_W-1:0];
        REG_TAP_MID:      tap_mid      <= pwdata[TAP_W-1:0];
        REG_TAP_LOW:      tap_low      <= pwdata[TAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (cfg_reg_t'(paddr[PADDR_W-1:2]))
      REG_FIELD_DEGREE: prdata = PDATA_W'(field_degree);
      REG_TAP_HIGH:     prdata = PDATA_W'(tap_high);
      REG_TAP_MID:      prdata = PDATA_W'(tap_mid);
      REG_TAP_LOW:      prdata = PDATA_W'(tap_low);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Field shape: saturate the degree, build the mask and the aligned
  // reduction polynomial so the carry always sits in the top bit
  // ---------------------------------------------------------------------------
  assign degree   = (field_degree > DEGREE_W'(W)) ? DW'(W) : DW'(field_degree);
  assign align_sh = DW'(W) - degree;
  assign mask     = ~({W{1'b1}} << degree);
  assign poly     = (W'(1) | (W'(1) << tap_high) | (W'(1) << tap_mid) |
                     (W'(1) << tap_low)) & mask;
  assign poly_al  = poly << align_sh;

  // ---------------------------------------------------------------------------
  // Entry register: mask the operands and left-align b
  // ---------------------------------------------------------------------------
  assign entry_ready   = !entry_valid || ch_ready[0];
  assign operand_stall = !entry_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (entry_ready) begin
      entry_valid <= operand_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (entry_ready) begin
      entry_a <= AW'(multiplier_a[W-1:0] & mask) << (AW - W);
      entry_b <= (multiplicand_b[W-1:0] & mask) << align_sh;
    end
  end

  // ---------------------------------------------------------------------------
  // Horner stages
  // ---------------------------------------------------------------------------
  assign ch_valid[0] = entry_valid;
  assign ch_s[0]     = '0;
  assign ch_a[0]     = entry_a;
  assign ch_b[0]     = entry_b;

  for (genvar g = 0; g < NSTG; g++) begin : g_stage
    gf2mpm_stage #(
      .W  (W),
      .AW (AW)
    ) u_stage (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (ch_valid[g]),
      .up_ready   (ch_ready[g]),
      .s_in       (ch_s[g]),
      .a_in       (ch_a[g]),
      .b_in       (ch_b[g]),
      .poly       (poly_al),
      .down_valid (ch_valid[g+1]),
      .down_ready (ch_ready[g+1]),
      .s_out      (ch_s[g+1]),
      .a_out      (ch_a[g+1]),
      .b_out      (ch_b[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Output register: shift the aligned result back down
  // ---------------------------------------------------------------------------
  assign out_ready      = !product_valid || !product_stall;
  assign ch_ready[NSTG] = out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      product_valid <= 1'b0;
    end else if (out_ready) begin
      product_valid <= ch_valid[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      product_q <= ch_s[NSTG] >> align_sh;
    end
  end

  assign product = DATA_W'(product_q);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_IMPLIES(a_product_reduced, clk, rst, product_valid, (product_q & ~mask) == '0)
  `ASSERT_IMPLIES(a_stall_only_full, clk, rst, operand_stall, entry_valid)
  `ASSERT_NEXT(a_transfer_lands, clk, rst, operand_valid && !operand_stall, entry_valid)
  `ASSERT_NEXT(a_last_stage_held, clk, rst, ch_valid[NSTG] && !out_ready, ch_valid[NSTG])

endmodule

[design/gf2mpm_stage.sv]
// ----------------------------------------------------------------------------
// gf2mpm_stage
// One pipeline stage of the multiplier: a group of Horner shift-reduce-add
// steps on a left-aligned accumulator, with its own valid and hand-back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gf2mpm_stage
  import gf2mpm_pkg::*;
#(
  parameter int W  = 64,
  parameter int AW = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  output logic          up_ready,
  input  logic [W-1:0]  s_in,
  input  logic [AW-1:0] a_in,
  input  logic [W-1:0]  b_in,
  input  logic [W-1:0]  poly,
  output logic          down_valid,
  input  logic          down_ready,
  output logic [W-1:0]  s_out,
  output logic [AW-1:0] a_out,
  output logic [W-1:0]  b_out
);

  logic [W-1:0] acc;
  logic         carry;

  // Shift, reduce on the top bit, add b for each bit of a, high bit first
  always_comb begin
    acc   = s_in;
    carry = 1'b0;
    for (int j = 0; j < STEPS_PER_STAGE; j++) begin
      carry = acc[W-1];
      acc   = acc << 1;
      if (carry) begin
        acc = acc ^ poly;
      end
      if (a_in[AW-1-j]) begin
        acc = acc ^ b_in;
      end
    end
  end

  // Take a new transfer when empty or when the next stage moves
  assign up_ready = !down_valid || down_ready;

  // Hold valid under reset
  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (up_ready) begin
      down_valid <= up_valid;
    end
  end

  // Advance the payload, dropping the consumed bits of a
  always_ff @(posedge clk) begin
    if (up_ready) begin
      s_out <= acc;
      a_out <= a_in << STEPS_PER_STAGE;
      b_out <= b_in;
    end
  end

endmodule
